>>> hdl/iee_pkg.sv
// Shared types, constants and arithmetic helpers for the infix expression evaluator.
package iee_pkg;

    localparam int STACK_DEPTH     = 32;
    localparam int FRAC_BITS       = 16;
    localparam int MAX_FRAC_DIGITS = 9;

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int CW   = $clog2(STACK_DEPTH + 1);
    localparam int DIVW = 32 + FRAC_BITS;

    localparam logic [15:0] INT_ACC_MAX = 16'hFFFF;
    localparam logic [31:0] POS_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MIN     = 32'h8000_0000;

    typedef enum logic [2:0] {
        OP_END   = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MUL   = 3'd3,
        OP_DIV   = 3'd4,
        OP_OPEN  = 3'd5,
        OP_CLOSE = 3'd6
    } t_op;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_ILLEGAL   = 2'd1;
    localparam t_status ST_DIVZERO   = 2'd2;
    localparam t_status ST_MALFORMED = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    function automatic logic [29:0] pow10(input logic [3:0] d);
        logic [29:0] p;
        case (d)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

    // Apply sign to a magnitude and clamp to the signed 32-bit range.
    function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] m);
        logic [31:0] r;
        if (neg) begin
            if (m > 64'(NEG_MIN)) r = NEG_MIN;
            else                  r = 32'd0 - m[31:0];
        end else begin
            if (m > 64'(POS_MAX)) r = POS_MAX;
            else                  r = m[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_sum(input logic [32:0] s);
        logic [31:0] r;
        if (s[32] != s[31]) r = s[32] ? NEG_MIN : POS_MAX;
        else                r = s[31:0];
        return r;
    endfunction

endpackage

>>> hdl/iee_ram.sv
// Simple dual-port RAM with registered read data, used for both stacks.
module iee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hdl/iee_div.sv
// Restoring divider, one quotient bit per cycle.
module iee_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [iee_pkg::DIVW-1:0]  i_dividend,
    input  logic [31:0]               i_divisor,
    output logic                      o_busy,
    output logic                      o_done,
    output logic [iee_pkg::DIVW-1:0]  o_quotient
);
    import iee_pkg::*;

    localparam int NW = $clog2(DIVW + 1);

    logic [32:0]     r_rem;
    logic [DIVW-1:0] r_quo;
    logic [31:0]     r_dvs;
    logic [NW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [32:0]     rem_sh;
    logic            fits;

    assign rem_sh = {r_rem[31:0], r_quo[DIVW-1]};
    assign fits   = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(DIVW);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                // shift in one dividend bit, subtract when it fits
                r_rem <= fits ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
                r_quo <= {r_quo[DIVW-2:0], fits};
                r_cnt <= r_cnt - NW'(1);
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

>>> hdl/infix_expression_evaluator.sv
// Top level: character intake, stack sequencer and result register of the evaluator.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------
//  input    | i_valid / o_ready   | i_character[7:0], i_last
//  output   | o_valid / i_ready   | o_value[31:0] (Q16.16), o_status[1:0]
//
// A digit or '.' updates the number accumulators. An operator request flushes a pending
// number (through the shared bit-serial divider, DIVW = 32 + FRAC_BITS bits wide, when the
// fraction accumulator is nonzero) and then runs one reduction per stacked operator of higher
// or equal precedence; '*' adds a saturation step and '/' a pass through the divider.
// The sequencer walks both stacks through their one read port, one access per
// state, so no read that it uses meets a write to the same entry in the same cycle.
// Reset (synchronous, active low) clears the counts, the number accumulators
// and the error latch; the stacks themselves need no clearing pass.
// The next request is taken once the sequencer is idle again; a result waits
// in the output register and stalls only the final step of the next expression.
module infix_expression_evaluator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_character,
    input  logic                  i_last,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [31:0]    o_value,
    output iee_pkg::t_status      o_status
);
    import iee_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE     = 19'h00001,
        S_CHK      = 19'h00002,
        S_FLUSH    = 19'h00004,
        S_FDIV     = 19'h00008,
        S_FPUSH    = 19'h00010,
        S_DISPATCH = 19'h00020,
        S_UNARY    = 19'h00040,
        S_TOP      = 19'h00080,
        S_TOPW     = 19'h00100,
        S_DECIDE   = 19'h00200,
        S_RESW     = 19'h00400,
        S_RHS      = 19'h00800,
        S_LHS      = 19'h01000,
        S_MAG      = 19'h02000,
        S_OPER     = 19'h04000,
        S_MSAT     = 19'h08000,
        S_RDIV     = 19'h10000,
        S_WB       = 19'h20000,
        S_EMIT     = 19'h40000
    } t_state;

    // control registers
    t_state         r_state, n_state;
    logic [CW-1:0]  r_opnd_cnt, n_opnd_cnt;
    logic [CW-1:0]  r_op_cnt, n_op_cnt;
    logic [15:0]    r_iacc, n_iacc;
    logic [29:0]    r_facc, n_facc;
    logic [3:0]     r_fdc, n_fdc;
    logic           r_in_num, n_in_num;
    logic           r_point, n_point;
    logic           r_prev_open, n_prev_open;
    logic           r_was_open, n_was_open;
    t_status        r_err, n_err;
    logic           r_last, n_last;
    logic           r_end_phase, n_end_phase;
    logic           r_ovalid, n_ovalid;
    // payload registers
    logic [7:0]     r_char, n_char;
    t_op            r_op, n_op;
    t_op            r_top, n_top;
    logic [DIVW-1:0] r_q, n_q;
    logic [31:0]    r_rhs, n_rhs;
    logic [31:0]    r_lhs, n_lhs;
    logic [31:0]    r_ma, n_ma;
    logic [31:0]    r_mb, n_mb;
    logic           r_neg, n_neg;
    logic [31:0]    r_sum, n_sum;
    logic [63:0]    r_prod, n_prod;
    logic [31:0]    r_res, n_res;
    logic [31:0]    r_result, n_result;
    logic [31:0]    r_ovalue, n_ovalue;
    t_status        r_ostatus, n_ostatus;

    // stack memory ports
    logic           opnd_we, op_we;
    logic [AW-1:0]  opnd_waddr, opnd_raddr, op_waddr, op_raddr;
    logic [31:0]    opnd_wdata, opnd_rdata;
    logic [2:0]     op_wdata, op_rdata;

    // divider port
    logic            div_start, div_busy, div_done;
    logic [DIVW-1:0] div_dividend, div_quotient;
    logic [31:0]     div_divisor;

    // scratch
    logic [19:0]     int_next;
    logic [29:0]     den;
    logic [DIVW:0]   whole;
    logic [CW-1:0]   cnt_m1, cnt_m2, opcnt_m1;
    logic            is_digit;
    logic            do_push, do_pop, do_end;
    logic            top_arith;

    iee_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_opnd_ram (
        .i_clk   (i_clk),
        .i_we    (opnd_we),
        .i_waddr (opnd_waddr),
        .i_wdata (opnd_wdata),
        .i_raddr (opnd_raddr),
        .o_rdata (opnd_rdata)
    );

    iee_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_op_ram (
        .i_clk   (i_clk),
        .i_we    (op_we),
        .i_waddr (op_waddr),
        .i_wdata (op_wdata),
        .i_raddr (op_raddr),
        .o_rdata (op_rdata)
    );

    iee_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_value  = r_ovalue;
    assign o_status = r_ostatus;

    assign cnt_m1   = r_opnd_cnt - CW'(1);
    assign cnt_m2   = r_opnd_cnt - CW'(2);
    assign opcnt_m1 = r_op_cnt - CW'(1);
    assign is_digit = (i_character >= CH_ZERO) && (i_character <= CH_NINE);
    assign int_next = 20'(r_iacc) * 20'd10 + 20'(i_character - CH_ZERO);
    assign den      = pow10(r_fdc);
    assign whole    = ((DIVW + 1)'(r_iacc) << FRAC_BITS) + (DIVW + 1)'(r_q);

    // precedence decision against the operator on top of the stack
    always_comb begin
        do_push = 1'b0;
        do_pop  = 1'b0;
        do_end  = 1'b0;
        case (r_op)
            OP_ADD, OP_SUB: do_push = (r_top == OP_END) || (r_top == OP_OPEN);
            OP_MUL, OP_DIV: do_push = (r_top != OP_MUL) && (r_top != OP_DIV);
            OP_OPEN:        do_push = 1'b1;
            OP_CLOSE:       do_pop  = (r_top == OP_OPEN);
            default:        do_end  = (r_top == OP_END);
        endcase
        top_arith = (r_top == OP_ADD) || (r_top == OP_SUB) ||
                    (r_top == OP_MUL) || (r_top == OP_DIV);
    end

    always_comb begin
        n_state     = r_state;
        n_opnd_cnt  = r_opnd_cnt;
        n_op_cnt    = r_op_cnt;
        n_iacc      = r_iacc;
        n_facc      = r_facc;
        n_fdc       = r_fdc;
        n_in_num    = r_in_num;
        n_point     = r_point;
        n_prev_open = r_prev_open;
        n_was_open  = r_was_open;
        n_err       = r_err;
        n_last      = r_last;
        n_end_phase = r_end_phase;
        n_ovalid    = r_ovalid;
        n_char      = r_char;
        n_op        = r_op;
        n_top       = r_top;
        n_q         = r_q;
        n_rhs       = r_rhs;
        n_lhs       = r_lhs;
        n_ma        = r_ma;
        n_mb        = r_mb;
        n_neg       = r_neg;
        n_sum       = r_sum;
        n_prod      = r_prod;
        n_res       = r_res;
        n_result    = r_result;
        n_ovalue    = r_ovalue;
        n_ostatus   = r_ostatus;

        opnd_we      = 1'b0;
        opnd_waddr   = r_opnd_cnt[AW-1:0];
        opnd_wdata   = r_res;
        opnd_raddr   = '0;
        op_we        = 1'b0;
        op_waddr     = r_op_cnt[AW-1:0];
        op_wdata     = r_op;
        op_raddr     = opcnt_m1[AW-1:0];
        div_start    = 1'b0;
        div_dividend = (DIVW'(r_facc) << FRAC_BITS) + DIVW'(den >> 1);
        div_divisor  = 32'(den);

        // drop the output once taken
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_char      = i_character;
                    n_last      = i_last;
                    n_end_phase = 1'b0;
                    n_state     = S_CHK;
                    if (r_err == ST_OK) begin
                        n_was_open  = r_prev_open;
                        n_prev_open = (i_character == CH_OPEN);
                        if (is_digit) begin
                            if (r_point) begin
                                if (r_fdc < 4'(MAX_FRAC_DIGITS)) begin
                                    n_facc = r_facc * 30'd10 + 30'(i_character - CH_ZERO);
                                    n_fdc  = r_fdc + 4'd1;
                                end
                            end else begin
                                n_iacc = (int_next > 20'(INT_ACC_MAX)) ? INT_ACC_MAX
                                                                       : int_next[15:0];
                            end
                            n_in_num = 1'b1;
                        end else if (i_character == CH_POINT) begin
                            if (r_point) begin
                                n_err = ST_MALFORMED;
                            end else begin
                                n_in_num = 1'b1;
                                n_point  = 1'b1;
                            end
                        end else begin
                            n_state = S_FLUSH;
                        end
                    end
                end
            end

            // finish the character; on the final one apply the end marker once
            S_CHK: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (!r_end_phase && r_err == ST_OK) begin
                    n_end_phase = 1'b1;
                    n_state     = S_FLUSH;
                end else begin
                    n_state = S_EMIT;
                end
            end

            S_FLUSH: begin
                if (!r_in_num) begin
                    n_state = S_DISPATCH;
                end else if (r_facc == 30'd0) begin
                    n_q     = '0;
                    n_state = S_FPUSH;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_FDIV;
                end
            end

            S_FDIV: begin
                if (div_done) begin
                    n_q     = div_quotient;
                    n_state = S_FPUSH;
                end
            end

            S_FPUSH: begin
                n_in_num = 1'b0;
                n_point  = 1'b0;
                n_iacc   = '0;
                n_facc   = '0;
                n_fdc    = '0;
                if (r_opnd_cnt >= CW'(STACK_DEPTH)) begin
                    n_err   = ST_MALFORMED;
                    n_state = S_CHK;
                end else begin
                    opnd_we    = 1'b1;
                    opnd_wdata = (whole > (DIVW + 1)'(POS_MAX)) ? POS_MAX : whole[31:0];
                    n_opnd_cnt = r_opnd_cnt + CW'(1);
                    n_state    = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                n_state = S_TOP;
                if (r_end_phase) begin
                    n_op = OP_END;
                end else if (r_char == CH_MINUS &&
                             (r_opnd_cnt == '0 || r_was_open)) begin
                    n_state = S_UNARY;
                end else begin
                    case (r_char)
                        CH_PLUS:  n_op = OP_ADD;
                        CH_MINUS: n_op = OP_SUB;
                        CH_STAR:  n_op = OP_MUL;
                        CH_SLASH: n_op = OP_DIV;
                        CH_OPEN:  n_op = OP_OPEN;
                        CH_CLOSE: n_op = OP_CLOSE;
                        default: begin
                            n_err   = ST_ILLEGAL;
                            n_state = S_CHK;
                        end
                    endcase
                end
            end

            // unary minus: push zero, then a subtract
            S_UNARY: begin
                n_state = S_CHK;
                if (r_opnd_cnt >= CW'(STACK_DEPTH)) begin
                    n_err = ST_MALFORMED;
                end else begin
                    opnd_we    = 1'b1;
                    opnd_wdata = '0;
                    n_opnd_cnt = r_opnd_cnt + CW'(1);
                    if (r_op_cnt >= CW'(STACK_DEPTH)) begin
                        n_err = ST_MALFORMED;
                    end else begin
                        op_we    = 1'b1;
                        op_wdata = OP_SUB;
                        n_op_cnt = r_op_cnt + CW'(1);
                    end
                end
            end

            // the bottom entry is always the end marker
            S_TOP: begin
                if (r_op_cnt == CW'(1)) begin
                    n_top   = OP_END;
                    n_state = S_DECIDE;
                end else begin
                    n_state = S_TOPW;
                end
            end

            S_TOPW: begin
                n_top   = t_op'(op_rdata);
                n_state = S_DECIDE;
            end

            S_DECIDE: begin
                n_state = S_CHK;
                if (do_push) begin
                    if (r_op_cnt >= CW'(STACK_DEPTH)) begin
                        n_err = ST_MALFORMED;
                    end else begin
                        op_we    = 1'b1;
                        n_op_cnt = r_op_cnt + CW'(1);
                    end
                end else if (do_pop) begin
                    n_op_cnt = opcnt_m1;
                end else if (do_end) begin
                    if (r_opnd_cnt != CW'(1)) begin
                        n_err = ST_MALFORMED;
                    end else begin
                        n_state = S_RESW;
                    end
                end else if (r_opnd_cnt < CW'(2) || !top_arith) begin
                    n_err = ST_MALFORMED;
                end else begin
                    opnd_raddr = cnt_m1[AW-1:0];
                    n_state    = S_RHS;
                end
            end

            S_RESW: begin
                n_result = opnd_rdata;
                n_state  = S_CHK;
            end

            S_RHS: begin
                n_rhs      = opnd_rdata;
                opnd_raddr = cnt_m2[AW-1:0];
                n_state    = S_LHS;
            end

            S_LHS: begin
                n_lhs   = opnd_rdata;
                n_state = S_MAG;
            end

            S_MAG: begin
                n_ma  = r_lhs[31] ? (32'd0 - r_lhs) : r_lhs;
                n_mb  = r_rhs[31] ? (32'd0 - r_rhs) : r_rhs;
                n_neg = r_lhs[31] ^ r_rhs[31];
                if (r_top == OP_SUB) begin
                    n_sum = sat_sum({r_lhs[31], r_lhs} - {r_rhs[31], r_rhs});
                end else begin
                    n_sum = sat_sum({r_lhs[31], r_lhs} + {r_rhs[31], r_rhs});
                end
                n_state = S_OPER;
            end

            S_OPER: begin
                case (r_top)
                    OP_MUL: begin
                        n_prod  = 64'(r_ma) * 64'(r_mb);
                        n_state = S_MSAT;
                    end
                    OP_DIV: begin
                        if (r_mb == 32'd0) begin
                            n_err   = ST_DIVZERO;
                            n_state = S_CHK;
                        end else begin
                            div_start    = 1'b1;
                            div_dividend = {r_ma, {FRAC_BITS{1'b0}}};
                            div_divisor  = r_mb;
                            n_state      = S_RDIV;
                        end
                    end
                    default: begin
                        n_res   = r_sum;
                        n_state = S_WB;
                    end
                endcase
            end

            S_MSAT: begin
                n_res   = sat_mag(r_neg, r_prod >> FRAC_BITS);
                n_state = S_WB;
            end

            S_RDIV: begin
                if (div_done) begin
                    n_res   = sat_mag(r_neg, 64'(div_quotient));
                    n_state = S_WB;
                end
            end

            // replace the two operands with the result, pop the operator, loop
            S_WB: begin
                opnd_we    = 1'b1;
                opnd_waddr = cnt_m2[AW-1:0];
                n_opnd_cnt = cnt_m1;
                n_op_cnt   = opcnt_m1;
                n_state    = S_TOP;
            end

            S_EMIT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid    = 1'b1;
                    n_ovalue    = (r_err == ST_OK) ? r_result : 32'd0;
                    n_ostatus   = r_err;
                    n_opnd_cnt  = '0;
                    n_op_cnt    = CW'(1);
                    n_iacc      = '0;
                    n_facc      = '0;
                    n_fdc       = '0;
                    n_in_num    = 1'b0;
                    n_point     = 1'b0;
                    n_prev_open = 1'b0;
                    n_err       = ST_OK;
                    n_result    = '0;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_opnd_cnt  <= '0;
            r_op_cnt    <= CW'(1);
            r_iacc      <= '0;
            r_facc      <= '0;
            r_fdc       <= '0;
            r_in_num    <= 1'b0;
            r_point     <= 1'b0;
            r_prev_open <= 1'b0;
            r_was_open  <= 1'b0;
            r_err       <= ST_OK;
            r_last      <= 1'b0;
            r_end_phase <= 1'b0;
            r_ovalid    <= 1'b0;
            r_result    <= '0;
        end else begin
            r_state     <= n_state;
            r_opnd_cnt  <= n_opnd_cnt;
            r_op_cnt    <= n_op_cnt;
            r_iacc      <= n_iacc;
            r_facc      <= n_facc;
            r_fdc       <= n_fdc;
            r_in_num    <= n_in_num;
            r_point     <= n_point;
            r_prev_open <= n_prev_open;
            r_was_open  <= n_was_open;
            r_err       <= n_err;
            r_last      <= n_last;
            r_end_phase <= n_end_phase;
            r_ovalid    <= n_ovalid;
            r_result    <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char    <= n_char;
        r_op      <= n_op;
        r_top     <= n_top;
        r_q       <= n_q;
        r_rhs     <= n_rhs;
        r_lhs     <= n_lhs;
        r_ma      <= n_ma;
        r_mb      <= n_mb;
        r_neg     <= n_neg;
        r_sum     <= n_sum;
        r_prod    <= n_prod;
        r_res     <= n_res;
        r_ovalue  <= n_ovalue;
        r_ostatus <= n_ostatus;
    end

    // the end marker at the bottom of the operator stack is never popped
    a_end_marker_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_op_cnt != '0)
        else $error("operator stack lost its end marker");

    a_opnd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_opnd_cnt <= CW'(STACK_DEPTH))
        else $error("operand count beyond stack depth");

    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_value == 32'd0))
        else $error("error result carries a nonzero value");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (r_state == S_IDLE && r_err == ST_OK && r_op_cnt == CW'(1)))
        else $error("result issued without returning to reset state");
endmodule
